### sv/assert_macros.svh
// Assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### sv/mies_pkg.sv
// Shared types and constants for the MIPS integer execute subset core
`default_nettype none
package mies_pkg;
    localparam int unsigned XLEN = 32;
    localparam int unsigned REG_AW = 5;

    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_ADDI  = 6'h08;

    localparam logic [5:0] FN_MFHI = 6'h10;
    localparam logic [5:0] FN_MFLO = 6'h12;
    localparam logic [5:0] FN_MULT = 6'h18;
    localparam logic [5:0] FN_DIV  = 6'h1A;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_XOR  = 6'h26;
    localparam logic [5:0] FN_SLT  = 6'h2A;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOEFF  = 2'd1;
    localparam logic [1:0] ST_DIVZ   = 2'd2;

    // Operation class chosen by the decoder
    typedef enum logic [3:0] {
        OPC_ADD, OPC_SUB, OPC_AND, OPC_OR, OPC_XOR, OPC_SLT,
        OPC_MFHI, OPC_MFLO, OPC_MULT, OPC_DIV, OPC_NONE
    } opc_t;

    // Request to the serial multiply/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } md_req_t;

    // Status from the serial multiply/divide unit
    typedef struct packed {
        logic done;
    } md_rsp_t;
endpackage
`default_nettype wire

### sv/mies_muldiv.sv
// Bit-serial signed multiply (shift-add) and divide (restoring), one bit per cycle
`default_nettype none
module mies_muldiv
    import mies_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire md_req_t           req,
    input  wire logic [XLEN-1:0]   op_a,
    input  wire logic [XLEN-1:0]   op_b,
    output md_rsp_t                rsp,
    output logic [XLEN-1:0]        hi_res,
    output logic [XLEN-1:0]        lo_res
);
    localparam int unsigned CW = $clog2(XLEN + 1);

    logic              busy_reg;
    logic              is_div_reg;
    logic [CW-1:0]     cnt_reg;
    logic [XLEN-1:0]   acc_reg;     // product high half / partial remainder
    logic [XLEN-1:0]   sh_reg;      // multiplier / dividend-quotient shift reg
    logic [XLEN-1:0]   mcand_reg;   // multiplicand or divisor magnitude
    logic              neg_q_reg;
    logic              neg_r_reg;
    logic              neg_p_reg;
    logic              done_reg;

    logic [XLEN-1:0]   mag_a;
    logic [XLEN-1:0]   mag_b;
    logic [XLEN:0]     add_sum;
    logic [XLEN:0]     rem_try;
    logic [XLEN:0]     sub_try;

    // Operand magnitudes
    assign mag_a = op_a[XLEN-1] ? (~op_a + 1'b1) : op_a;
    assign mag_b = op_b[XLEN-1] ? (~op_b + 1'b1) : op_b;

    // Multiply step: add multiplicand when low bit set
    assign add_sum = {1'b0, acc_reg} + (sh_reg[0] ? {1'b0, mcand_reg} : '0);
    // Divide step: shift in next dividend bit and try subtract
    assign rem_try = {acc_reg, sh_reg[XLEN-1]};
    assign sub_try = rem_try - {1'b0, mcand_reg};

    // Final sign fixes on the 64-bit product and on quotient/remainder
    logic [2*XLEN-1:0] prod_mag;
    logic [2*XLEN-1:0] prod_s;
    assign prod_mag = {acc_reg, sh_reg};
    assign prod_s   = neg_p_reg ? (~prod_mag + 1'b1) : prod_mag;

    always_comb
    begin
        if (is_div_reg)
        begin
            hi_res = neg_r_reg ? (~acc_reg + 1'b1) : acc_reg;
            lo_res = neg_q_reg ? (~sh_reg + 1'b1) : sh_reg;
        end
        else
        begin
            hi_res = prod_s[2*XLEN-1:XLEN];
            lo_res = prod_s[XLEN-1:0];
        end
    end

    assign rsp.done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(XLEN);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath shift registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            is_div_reg <= req.is_div;
            acc_reg    <= '0;
            sh_reg     <= mag_a;
            mcand_reg  <= mag_b;
            neg_p_reg  <= op_a[XLEN-1] ^ op_b[XLEN-1];
            neg_q_reg  <= op_a[XLEN-1] ^ op_b[XLEN-1];
            neg_r_reg  <= op_a[XLEN-1];
        end
        else if (busy_reg)
        begin
            if (is_div_reg)
            begin
                if (!sub_try[XLEN])
                begin
                    acc_reg <= sub_try[XLEN-1:0];
                    sh_reg  <= {sh_reg[XLEN-2:0], 1'b1};
                end
                else
                begin
                    acc_reg <= rem_try[XLEN-1:0];
                    sh_reg  <= {sh_reg[XLEN-2:0], 1'b0};
                end
            end
            else
            begin
                acc_reg <= add_sum[XLEN:1];
                sh_reg  <= {add_sum[0], sh_reg[XLEN-1:1]};
            end
        end
    end
endmodule
`default_nettype wire

### sv/mips_integer_execute_subset_core.sv
// Top level: decode, register file, simple ALU and serial multiply/divide sequencing
//
//  channel | dir | handshake                   | payload
//  input   | in  | in_valid / in_ready         | instruction_word
//  output  | out | out_valid / out_ready       | status, write_enable, write_register,
//          |     |                             | write_value, hi_now, lo_now
//
// Single-cycle ops go from transfer to result through register file read, execute
// and write back. MULT, and DIV with a nonzero divisor, also pass through the
// bit-serial unit (one bit per cycle) between execute and write back. Register
// file is a memory; its 32 entries are cleared by a sweep after reset, in_ready
// low meanwhile. One item at a time; the result register waits on out_ready, and
// a new item is taken only once the held result goes out, at the earliest in the
// same cycle.
`default_nettype none
module mips_integer_execute_subset_core
    import mies_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [31:0]         instruction_word,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [1:0]               status,
    output logic                     write_enable,
    output logic [4:0]               write_register,
    output logic signed [31:0]       write_value,
    output logic signed [31:0]       hi_now,
    output logic signed [31:0]       lo_now
);
    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_EXEC, S_MD, S_WB} state_t;

    state_t            state_reg;
    logic [REG_AW-1:0] clr_reg;
    logic [31:0]       instr_reg;
    logic [XLEN-1:0]   a_reg, b_reg;
    logic [XLEN-1:0]   hi_reg, lo_reg;
    logic [XLEN-1:0]   val_reg;
    logic              we_reg;
    logic [REG_AW-1:0] dst_reg;
    logic [1:0]        st_reg;
    logic              out_valid_reg;
    logic [1:0]        o_status_reg;
    logic              o_we_reg;
    logic [REG_AW-1:0] o_dst_reg;
    logic [XLEN-1:0]   o_val_reg;

    logic [XLEN-1:0]   rf [32];

    md_req_t           md_req;
    md_rsp_t           md_rsp;
    logic [XLEN-1:0]   md_hi, md_lo;

    // Decode
    logic [5:0] opcode, funct;
    opc_t       opc;
    assign opcode = instr_reg[31:26];
    assign funct  = instr_reg[5:0];

    always_comb
    begin
        opc = OPC_NONE;
        if (opcode == OP_ADDI)
            opc = OPC_ADD;
        else if (opcode == OP_RTYPE)
        begin
            unique case (funct)
                FN_ADD:  opc = OPC_ADD;
                FN_SUB:  opc = OPC_SUB;
                FN_AND:  opc = OPC_AND;
                FN_OR:   opc = OPC_OR;
                FN_XOR:  opc = OPC_XOR;
                FN_SLT:  opc = OPC_SLT;
                FN_MFHI: opc = OPC_MFHI;
                FN_MFLO: opc = OPC_MFLO;
                FN_MULT: opc = OPC_MULT;
                FN_DIV:  opc = OPC_DIV;
                default: opc = OPC_NONE;
            endcase
        end
    end

    // Second operand: sign-extended immediate for ADDI
    logic [XLEN-1:0] opb;
    assign opb = (opcode == OP_ADDI) ? {{16{instr_reg[15]}}, instr_reg[15:0]} : b_reg;

    logic [XLEN-1:0] alu;
    always_comb
    begin
        unique case (opc)
            OPC_ADD:  alu = a_reg + opb;
            OPC_SUB:  alu = a_reg - b_reg;
            OPC_AND:  alu = a_reg & b_reg;
            OPC_OR:   alu = a_reg | b_reg;
            OPC_XOR:  alu = a_reg ^ b_reg;
            OPC_SLT:  alu = {31'd0, ($signed(a_reg) < $signed(b_reg))};
            OPC_MFHI: alu = hi_reg;
            OPC_MFLO: alu = lo_reg;
            default:  alu = '0;
        endcase
    end

    logic writes;
    logic [REG_AW-1:0] dst;
    assign writes = (opc == OPC_ADD) || (opc == OPC_SUB) || (opc == OPC_AND)
                 || (opc == OPC_OR) || (opc == OPC_XOR) || (opc == OPC_SLT)
                 || (opc == OPC_MFHI) || (opc == OPC_MFLO);
    assign dst = (opcode == OP_ADDI) ? instr_reg[20:16] : instr_reg[15:11];

    assign md_req.start  = (state_reg == S_EXEC)
                        && ((opc == OPC_MULT) || ((opc == OPC_DIV) && (b_reg != '0)));
    assign md_req.is_div = (opc == OPC_DIV);

    mies_muldiv u_md (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (md_req),
        .op_a   (a_reg),
        .op_b   (b_reg),
        .rsp    (md_rsp),
        .hi_res (md_hi),
        .lo_res (md_lo)
    );

    // Register file: clear sweep and write-back, registered reads
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
            rf[clr_reg] <= '0;
        else if ((state_reg == S_WB) && we_reg)
            rf[dst_reg] <= val_reg;
        if (state_reg == S_READ)
        begin
            a_reg <= rf[instr_reg[25:21]];
            b_reg <= rf[instr_reg[20:16]];
        end
    end

    assign in_ready = (state_reg == S_IDLE) && !(out_valid_reg && !out_ready);

    // Control sequencer with registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            hi_reg        <= '0;
            lo_reg        <= '0;
            we_reg        <= 1'b0;
            instr_reg     <= '0;
            dst_reg       <= '0;
            val_reg       <= '0;
            st_reg        <= ST_OK;
            o_status_reg  <= ST_OK;
            o_we_reg      <= 1'b0;
            o_dst_reg     <= '0;
            o_val_reg     <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == '1)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        instr_reg <= instruction_word;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                    state_reg <= S_EXEC;
                S_EXEC:
                begin
                    we_reg  <= writes && (dst != '0);
                    dst_reg <= (writes && (dst != '0)) ? dst : '0;
                    val_reg <= (writes && (dst != '0)) ? alu : '0;
                    if (opc == OPC_NONE)
                        st_reg <= ST_NOEFF;
                    else if ((opc == OPC_DIV) && (b_reg == '0))
                        st_reg <= ST_DIVZ;
                    else
                        st_reg <= ST_OK;
                    state_reg <= md_req.start ? S_MD : S_WB;
                end
                S_MD:
                begin
                    if (md_rsp.done)
                    begin
                        hi_reg    <= md_hi;
                        lo_reg    <= md_lo;
                        state_reg <= S_WB;
                    end
                end
                S_WB:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        o_status_reg  <= st_reg;
                        o_we_reg      <= we_reg;
                        o_dst_reg     <= dst_reg;
                        o_val_reg     <= val_reg;
                        we_reg        <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // hi/lo shown with the result are latched with it
    logic [XLEN-1:0] o_hi_reg, o_lo_reg;
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_WB) && (!out_valid_reg || out_ready))
        begin
            o_hi_reg <= hi_reg;
            o_lo_reg <= lo_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = o_status_reg;
    assign write_enable   = o_we_reg;
    assign write_register = o_dst_reg;
    assign write_value    = o_val_reg;
    assign hi_now         = o_hi_reg;
    assign lo_now         = o_lo_reg;
endmodule
`default_nettype wire

### sv/mies_checker.sv
// Port-level checker for the execute core, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module mies_checker
    import mies_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  status,
    input wire logic        write_enable,
    input wire logic [4:0]  write_register,
    input wire logic [31:0] write_value
);
    `ASSERT_IMPL(a_out_stable, clk, rst_n, out_valid && !out_ready, ##1 (out_valid && $stable(status) && $stable(write_value)), "result changed while stalled")
    `ASSERT_IMPL(a_no_r0, clk, rst_n, out_valid && write_enable, write_register != 5'd0, "write to register zero reported")
    `ASSERT_IMPL(a_noeff, clk, rst_n, out_valid && (status != ST_OK), !write_enable && (write_value == 32'd0), "write reported without execution")
    `ASSERT_IMPL(a_status, clk, rst_n, out_valid, status != 2'd3, "bad status code")
    `ASSERT_NEXT(a_one_busy, clk, rst_n, in_valid && in_ready, !in_ready, "second item taken while busy")
endmodule

bind mips_integer_execute_subset_core mies_checker u_mies_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .write_enable   (write_enable),
    .write_register (write_register),
    .write_value    (write_value)
);
`default_nettype wire
